/* sv/digital_trace_run_extractor_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trace run extractor
// Clocked on i_clk and quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef DIGITAL_TRACE_RUN_EXTRACTOR_ASSERT_SVH
`define DIGITAL_TRACE_RUN_EXTRACTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every edge out of reset
`define DRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define DRT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`else

`define DRT_ASSERT(lbl, prop, msg)
`define DRT_NEVER(lbl, expr, msg)

`endif

`endif

/* sv/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg
// Types, constants and helpers shared by the trace run extractor modules
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int TIME_W     = 48;
    localparam int FRAC_W     = 16;
    localparam int SCALE_W    = 32;
    localparam int PROD_W     = 2 * SCALE_W;
    localparam int FRAC_SHIFT = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // configuration register index
    typedef enum logic [1:0] {
        CFG_VIEW_START  = 2'd0,
        CFG_VIEW_END    = 2'd1,
        CFG_MIN_RUN_LEN = 2'd2,
        CFG_FRAC_SCALE  = 2'd3
    } t_cfg_idx;

    // input sample
    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic              level;
        logic              frame_end;
    } t_sample;

    // drawn run
    typedef struct packed {
        logic [FRAC_W-1:0] run_begin;
        logic [FRAC_W-1:0] run_stop;
        logic              last_run;
        logic              no_runs;
    } t_run;

    // configuration set
    typedef struct packed {
        logic [TIME_W-1:0]  view_start;
        logic [TIME_W-1:0]  view_end;
        logic [TIME_W-1:0]  min_run_len;
        logic [SCALE_W-1:0] frac_scale;
    } t_cfg;

    // run in time units, queued between front and back
    typedef struct packed {
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] end_t;
        logic              last;
        logic              none;
    } t_span;

    // up to two spans per sample, packed toward slot a
    typedef struct packed {
        logic [1:0] cnt;
        t_span      a;
        t_span      b;
    } t_push;

    // time sum saturating at the largest time
    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

/* sv/drt_front.sv */
// ----------------------------------------------------------------------------
// drt_front
// Tracks open and held runs per sample and pushes finished spans
// ----------------------------------------------------------------------------
module drt_front
    import drt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    input  logic    i_room,
    output t_push   o_push
);

`include "digital_trace_run_extractor_assert.svh"

    logic              r_in_run, n_in_run;
    logic              r_held_valid, n_held_valid;
    logic              r_window_done, n_window_done;
    logic [TIME_W-1:0] r_open_start, n_open_start;
    logic [TIME_W-1:0] r_held_start, n_held_start;
    logic [TIME_W-1:0] r_held_end, n_held_end;

    logic              acc;
    logic              active, past, in_window, high, fe;
    logic              open_now, close_w, close_f, do_close, in_run_mid, merge;
    logic [TIME_W-1:0] t, open_eff, end_t, re_sum, re_max, re;
    logic [TIME_W-1:0] hs_after, he_after;
    logic              hv_after, emit_held;
    t_span             span_held, span_last;

    assign o_ready = i_room;
    assign acc     = i_valid && o_ready;

    // sample classification
    always_comb begin
        t         = i_sample.sample_time;
        high      = i_sample.level;
        fe        = i_sample.frame_end;
        active    = !r_window_done;
        past      = t > i_cfg.view_end;
        in_window = (t >= i_cfg.view_start) && !past;
    end

    // run open and close decisions
    always_comb begin
        open_now   = active && in_window && high && !r_in_run;
        close_w    = active && r_in_run && (past || (in_window && !high));
        in_run_mid = open_now || (r_in_run && !close_w);
        close_f    = fe && in_run_mid;
        do_close   = close_w || close_f;
        open_eff   = open_now ? t : r_open_start;
        end_t      = (close_w && !past) ? t : i_cfg.view_end;
    end

    // widened run end and merge test
    always_comb begin
        re_sum = sat_add(open_eff, i_cfg.min_run_len);
        re_max = (end_t > re_sum) ? end_t : re_sum;
        re     = (re_max > i_cfg.view_end) ? i_cfg.view_end : re_max;
        merge  = r_held_valid && (open_eff <= sat_add(r_held_end, i_cfg.min_run_len));
    end

    // held run after an optional close
    always_comb begin
        emit_held = do_close && r_held_valid && !merge;
        hv_after  = r_held_valid || do_close;
        hs_after  = r_held_start;
        he_after  = r_held_end;
        if (do_close) begin
            if (merge) begin
                he_after = (re > r_held_end) ? re : r_held_end;
            end else begin
                hs_after = open_eff;
                he_after = re;
            end
        end
    end

    // spans to queue
    always_comb begin
        span_held.start_t = r_held_start;
        span_held.end_t   = r_held_end;
        span_held.last    = 1'b0;
        span_held.none    = 1'b0;
        span_last.start_t = hv_after ? hs_after : '0;
        span_last.end_t   = hv_after ? he_after : '0;
        span_last.last    = 1'b1;
        span_last.none    = !hv_after;
        o_push.a          = emit_held ? span_held : span_last;
        o_push.b          = span_last;
        o_push.cnt        = 2'd0;
        if (acc) begin
            o_push.cnt = 2'({1'b0, emit_held} + {1'b0, fe});
        end
    end

    // next frame state
    always_comb begin
        n_in_run      = in_run_mid && !close_f;
        n_window_done = r_window_done || (active && past);
        n_open_start  = open_eff;
        n_held_valid  = hv_after;
        n_held_start  = hs_after;
        n_held_end    = he_after;
        if (fe) begin
            n_in_run      = 1'b0;
            n_window_done = 1'b0;
            n_open_start  = '0;
            n_held_valid  = 1'b0;
            n_held_start  = '0;
            n_held_end    = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run      <= 1'b0;
            r_held_valid  <= 1'b0;
            r_window_done <= 1'b0;
            r_open_start  <= '0;
            r_held_start  <= '0;
            r_held_end    <= '0;
        end else if (acc) begin
            r_in_run      <= n_in_run;
            r_held_valid  <= n_held_valid;
            r_window_done <= n_window_done;
            r_open_start  <= n_open_start;
            r_held_start  <= n_held_start;
            r_held_end    <= n_held_end;
        end
    end

    // a passed window never leaves a run open
    `DRT_NEVER(a_done_open, r_window_done && r_in_run, "run open after window passed")
    // frame end always pushes its last span
    `DRT_ASSERT(a_fe_push, (acc && fe) |-> (o_push.cnt != 2'd0), "frame end pushed nothing")

endmodule

/* sv/drt_fifo.sv */
// ----------------------------------------------------------------------------
// drt_fifo
// Short span queue, takes up to two spans a cycle and gives one
// ----------------------------------------------------------------------------
module drt_fifo
    import drt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    input  logic  i_pop,
    output logic  o_avail,
    output t_span o_head
);

`include "digital_trace_run_extractor_assert.svh"

    t_span                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_PTR_W:0]   r_count, n_count;
    logic [FIFO_PTR_W-1:0] wr_next;

    assign wr_next = r_wr + FIFO_PTR_W'(1);
    assign o_room  = r_count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2);
    assign o_avail = r_count != '0;
    assign o_head  = r_mem[r_rd];

    // pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + FIFO_PTR_W'(i_push.cnt);
        n_rd    = r_rd + FIFO_PTR_W'(i_pop);
        n_count = r_count + (FIFO_PTR_W + 1)'(i_push.cnt) - (FIFO_PTR_W + 1)'(i_pop);
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.b;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `DRT_NEVER(a_fifo_over, r_count > (FIFO_PTR_W + 1)'(FIFO_DEPTH), "span queue overflow")
    `DRT_NEVER(a_pop_empty, i_pop && (r_count == '0), "pop from empty span queue")

endmodule

/* sv/drt_back.sv */
// ----------------------------------------------------------------------------
// drt_back
// Converts queued spans to window fractions and holds the result register
// ----------------------------------------------------------------------------
module drt_back
    import drt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_avail,
    input  t_span i_head,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_run  o_data
);

`include "digital_trace_run_extractor_assert.svh"

    localparam logic [FRAC_W-1:0] FMAX = {FRAC_W{1'b1}};

    // fraction from split products
    function automatic logic [FRAC_W-1:0] frac_of(
        input logic              lt,
        input logic [PROD_W-1:0] plo,
        input logic [PROD_W-1:0] phi
    );
        logic [PROD_W:0]                tot;
        logic [PROD_W-FRAC_SHIFT-1:0]   q;
        tot = {1'b0, phi[SCALE_W-1:0], {SCALE_W{1'b0}}} + {1'b0, plo};
        q   = tot[PROD_W-1:FRAC_SHIFT];
        if (lt) begin
            return '0;
        end else if (phi[PROD_W-1:SCALE_W] != '0 || tot[PROD_W]) begin
            return FMAX;
        end else if (q > (PROD_W - FRAC_SHIFT)'(FMAX)) begin
            return FMAX;
        end
        return q[FRAC_W-1:0];
    endfunction

    logic                en;
    logic                r_va, r_vb, r_out_valid;
    logic                r_last_a, r_none_a, r_last_b, r_none_b;
    logic                r_lt_b_a, r_lt_e_a, r_lt_b_b, r_lt_e_b;
    logic [PROD_W-1:0]   r_dx_b, r_dx_e;
    logic [PROD_W-1:0]   r_plo_b, r_phi_b, r_plo_e, r_phi_e;
    logic [PROD_W-1:0]   scale_x;
    t_run                r_out_data, n_out_data;

    // whole pipe moves unless the result register is stuck
    assign en      = !r_out_valid || i_ready;
    assign o_pop   = en && i_avail;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign scale_x = PROD_W'(i_cfg.frac_scale);

    // offset from window start
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lt_b_a <= i_head.start_t < i_cfg.view_start;
            r_lt_e_a <= i_head.end_t < i_cfg.view_start;
            r_dx_b   <= PROD_W'(i_head.start_t - i_cfg.view_start);
            r_dx_e   <= PROD_W'(i_head.end_t - i_cfg.view_start);
            r_last_a <= i_head.last;
            r_none_a <= i_head.none;
        end
    end

    // split products, low and high word of the offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plo_b  <= PROD_W'(r_dx_b[SCALE_W-1:0]) * scale_x;
            r_phi_b  <= PROD_W'(r_dx_b[PROD_W-1:SCALE_W]) * scale_x;
            r_plo_e  <= PROD_W'(r_dx_e[SCALE_W-1:0]) * scale_x;
            r_phi_e  <= PROD_W'(r_dx_e[PROD_W-1:SCALE_W]) * scale_x;
            r_lt_b_b <= r_lt_b_a;
            r_lt_e_b <= r_lt_e_a;
            r_last_b <= r_last_a;
            r_none_b <= r_none_a;
        end
    end

    // combine, saturate, zero for an empty frame
    always_comb begin
        n_out_data.run_begin = frac_of(r_lt_b_b, r_plo_b, r_phi_b);
        n_out_data.run_stop  = frac_of(r_lt_e_b, r_plo_e, r_phi_e);
        n_out_data.last_run  = r_last_b;
        n_out_data.no_runs   = r_none_b;
        if (r_none_b) begin
            n_out_data.run_begin = '0;
            n_out_data.run_stop  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_va        <= i_avail;
            r_vb        <= r_va;
            r_out_valid <= r_vb;
        end
    end

    `DRT_ASSERT(a_none_zero, (r_out_valid && r_out_data.no_runs) |->
        (r_out_data.run_begin == '0 && r_out_data.run_stop == '0 && r_out_data.last_run),
        "empty frame result malformed")

endmodule

/* sv/digital_trace_run_extractor.sv */
// ----------------------------------------------------------------------------
// digital_trace_run_extractor
// High run extractor for one digital channel, with window configuration
// ----------------------------------------------------------------------------
// path: the first result of a sample passes the span queue, the offset and product stages
//   and the result register; a second result of the same sample follows it
// throughput: one sample per cycle while the span queue has two free slots;
//   the fraction pipe drains one result per cycle while the output is not stalled
// reset: synchronous active low, clears run state, queue, pipe and registers
//   (view_end to all ones, the others to zero)
module digital_trace_run_extractor
    import drt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_sample           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_run              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_push push;
    t_span head;
    logic  room, avail, pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_start  <= '0;
            r_cfg.view_end    <= {TIME_W{1'b1}};
            r_cfg.min_run_len <= '0;
            r_cfg.frac_scale  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VIEW_START:  r_cfg.view_start  <= i_cfg_data;
                CFG_VIEW_END:    r_cfg.view_end    <= i_cfg_data;
                CFG_MIN_RUN_LEN: r_cfg.min_run_len <= i_cfg_data;
                CFG_FRAC_SCALE:  r_cfg.frac_scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    drt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_in_data),
        .i_cfg    (r_cfg),
        .i_room   (room),
        .o_push   (push)
    );

    drt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .i_pop   (pop),
        .o_avail (avail),
        .o_head  (head)
    );

    drt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (avail),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
